FILE: rtl/core/rws_pkg.sv
// rws_pkg: shared types and constants for the roulette wheel selector.
// No dependencies; imported by every module of the block.
package rws_pkg;

	localparam int MAX_POP_DEF   = 256;
	localparam int COST_BITS_DEF = 32;
	localparam int IDX_W         = 8;
	localparam int COST_IN_W     = 32;
	localparam int FRAC_W        = 16;
	localparam int CNT_W         = 9;
	localparam int MODE_W        = 2;
	localparam int POP_W         = 9;
	localparam int CFG_W         = 9;
	localparam int CFG_IDX_W     = 1;
	localparam int TOTAL_W       = 40;
	localparam int PTR_W         = TOTAL_W + FRAC_W;
	localparam int DIV_STEPS     = PTR_W;
	localparam int DCNT_W        = $clog2(DIV_STEPS + 1);

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_PREP = 2'd1,
		OP_SEL  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	localparam logic [MODE_W-1:0] MODE_ROUL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RANK = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POP  = 1'd1;

	typedef struct packed {
		logic capture;
		logic mem_wr;
		logic walk_init;
		logic for_select;
		logic sum_step;
		logic walk_step;
		logic mul;
		logic div_start;
		logic div_src_ptr;
		logic div_step;
		logic set_step;
		logic set_ptr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic at_end;
		logic walk_done;
		logic div_done;
		logic out_busy;
	} stat_t;

endpackage

FILE: rtl/core/rws_if.sv
// rws_in_if / rws_out_if: request and result channels with valid/ready.
// Depends on rws_pkg for field widths.
interface rws_in_if import rws_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           opcode;
	logic [IDX_W-1:0]     entry_index;
	logic [COST_IN_W-1:0] cost_value;
	logic [FRAC_W-1:0]    random_fraction;
	logic [CNT_W-1:0]     selection_count;

	modport source (output valid, opcode, entry_index, cost_value, random_fraction,
		selection_count, input ready);
	modport sink (input valid, opcode, entry_index, cost_value, random_fraction,
		selection_count, output ready);
endinterface

interface rws_out_if import rws_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] selected_index;
	logic             ran_past_end;

	modport source (output valid, selected_index, ran_past_end, input ready);
	modport sink (input valid, selected_index, ran_past_end, output ready);
endinterface

FILE: rtl/core/roulette_wheel_selector_top.sv
// roulette_wheel_selector_top: weight-proportional parent selector.
// Depends on rws_pkg, rws_if, rws_ctrl and rws_dp.
//
//  channel   dir   handshake        contents
//  in_ch     in    valid/ready      opcode, entry_index, cost_value, random_fraction,
//                                   selection_count
//  out_ch    out   valid/ready      selected_index, ran_past_end
//  cfg       in    cfg_we           cfg_index (0 mode, 1 population), cfg_data
//
// Load writes the cost memory. Prepare sums the table, then runs two
// 56-step divides in one shared radix-2 divider. Select walks the cost
// memory read port one entry per cycle. Reset sets mode to roulette and
// population to 256 and clears total and sampling state; the cost table is
// not cleared. A result waiting on out_ch stalls the next select and the requests after it.
module roulette_wheel_selector_top import rws_pkg::*; #(
	parameter int MAX_POPULATION = MAX_POP_DEF,
	parameter int COST_BITS      = COST_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rws_in_if.sink               in_ch,
	rws_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cmd_t  cmd;
	stat_t st;

	rws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.in_ready  (in_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	rws_dp #(
		.MAX_POPULATION (MAX_POPULATION),
		.COST_BITS      (COST_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_idx    (in_ch.entry_index),
		.in_cost   (in_ch.cost_value),
		.in_frac   (in_ch.random_fraction),
		.in_cnt    (in_ch.selection_count),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_sel   (out_ch.selected_index),
		.out_past  (out_ch.ran_past_end)
	);

endmodule

FILE: rtl/core/rws_ctrl.sv
// rws_ctrl: sequencing state machine for load, prepare and select requests.
// Depends on rws_pkg; drives rws_dp through cmd_t and reads stat_t.
module rws_ctrl import rws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_opcode,
	output logic       in_ready,
	input  stat_t      st,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_PINIT, S_SUM, S_PMUL, S_DIV1, S_DIV2,
		S_MUL, S_WINIT, S_WALK, S_HOLD
	} state_t;

	state_t state_q, state_d;
	op_t    op;
	logic   accept;

	assign op       = op_t'(in_opcode);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = accept;
				cmd.mem_wr  = accept && (op == OP_LOAD);
				if (accept && op == OP_PREP) state_d = S_PINIT;
				if (accept && op == OP_SEL)  state_d = S_MUL;
			end
			S_PINIT: begin
				cmd.walk_init = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum_step = 1'b1;
				if (st.at_end) state_d = S_PMUL;
			end
			S_PMUL: begin
				cmd.mul       = 1'b1;
				cmd.div_start = 1'b1;
				state_d = S_DIV1;
			end
			S_DIV1: begin
				cmd.div_step = 1'b1;
				if (st.div_done) begin
					cmd.set_step    = 1'b1;
					cmd.div_start   = 1'b1;
					cmd.div_src_ptr = 1'b1;
					state_d = S_DIV2;
				end
			end
			S_DIV2: begin
				cmd.div_step = 1'b1;
				if (st.div_done) begin
					cmd.set_ptr = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_WINIT;
			end
			S_WINIT: begin
				cmd.walk_init  = 1'b1;
				cmd.for_select = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (st.walk_done) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/rws_dp.sv
// rws_dp: cost memory, weight walk, total/pointer registers, divider, result reg.
// Depends on rws_pkg; commanded by rws_ctrl.
module rws_dp import rws_pkg::*; #(
	parameter int MAX_POPULATION = MAX_POP_DEF,
	parameter int COST_BITS      = COST_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                st,
	input  logic [IDX_W-1:0]     in_idx,
	input  logic [COST_IN_W-1:0] in_cost,
	input  logic [FRAC_W-1:0]    in_frac,
	input  logic [CNT_W-1:0]     in_cnt,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [IDX_W-1:0]     out_sel,
	output logic                 out_past
);

	localparam int AW = $clog2(MAX_POPULATION);
	localparam int NW = $clog2(MAX_POPULATION + 1);

	logic [COST_BITS-1:0] mem [MAX_POPULATION];
	logic [COST_BITS-1:0] rdata_q;
	logic [AW-1:0]        rd_addr;

	logic [MODE_W-1:0]  mode_q;
	logic [POP_W-1:0]   pop_q;
	logic [TOTAL_W-1:0] total_q, srun_q, run_q;
	logic [PTR_W-1:0]   step_q, ptr_q, target_q, prod_q, quo_q;
	logic [NW-1:0]      spos_q, pos_q;
	logic [FRAC_W-1:0]  r_q;
	logic [CNT_W-1:0]   cnt_q, rem_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [IDX_W-1:0]   pick_idx_q;
	logic               pick_past_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic               res_past_q;
	logic               out_valid_q;

	logic [NW-1:0]      n_eff, init_pos, pos_inc;
	logic               samp, rank, found, at_end, walk_done, idx_ok;
	logic [TOTAL_W-1:0] weight, cand;
	logic [CNT_W:0]     trial;
	logic               ge;
	logic [PTR_W:0]     ptr_sum;

	always_comb begin
		if (pop_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(pop_q) > MAX_POPULATION) begin
			n_eff = NW'(MAX_POPULATION);
		end else begin
			n_eff = NW'(pop_q);
		end
	end

	assign samp      = (mode_q == MODE_SUS);
	assign rank      = (mode_q == MODE_RANK);
	assign pos_inc   = pos_q + 1'b1;
	assign init_pos  = (cmd.for_select && samp) ? spos_q : '0;
	assign rd_addr   = cmd.walk_init ? init_pos[AW-1:0] : pos_inc[AW-1:0];
	assign idx_ok    = 32'(in_idx) < MAX_POPULATION;
	assign weight    = rank ? TOTAL_W'(n_eff - pos_q) : TOTAL_W'(rdata_q);
	assign cand      = run_q + weight;
	assign at_end    = pos_q >= n_eff;
	// scaled compare: running sum times 65536 against the target
	assign found     = !at_end && ({cand, {FRAC_W{1'b0}}} >= target_q);
	assign walk_done = at_end || found;
	assign trial     = {rem_q, quo_q[PTR_W-1]};
	assign ge        = trial >= {1'b0, cnt_q};
	assign ptr_sum   = {1'b0, ptr_q} + {1'b0, step_q};

	assign st.at_end    = at_end;
	assign st.walk_done = walk_done;
	assign st.div_done  = (dcnt_q == '0);
	assign st.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_sel   = res_idx_q;
	assign out_past  = res_past_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && idx_ok) begin
			mem[AW'(in_idx)] <= COST_BITS'(in_cost);
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			r_q   <= in_frac;
			cnt_q <= (in_cnt == '0) ? CNT_W'(1) : in_cnt;
		end
		if (cmd.walk_init) begin
			pos_q    <= init_pos;
			run_q    <= (cmd.for_select && samp) ? srun_q : '0;
			target_q <= samp ? ptr_q : prod_q;
		end else if ((cmd.sum_step && !at_end) || (cmd.walk_step && !walk_done)) begin
			run_q <= cand;
			pos_q <= pos_inc;
		end
		// pick is held here until the result register is free
		if (cmd.walk_step && walk_done) begin
			pick_idx_q  <= found ? IDX_W'(pos_q) : IDX_W'(n_eff - 1'b1);
			pick_past_q <= !found;
		end
		if (cmd.out_load) begin
			res_idx_q  <= pick_idx_q;
			res_past_q <= pick_past_q;
		end
		if (cmd.mul) begin
			prod_q <= PTR_W'(r_q * total_q);
		end
		if (cmd.div_start) begin
			quo_q <= cmd.div_src_ptr ? prod_q : {total_q, {FRAC_W{1'b0}}};
			rem_q <= '0;
		end else if (cmd.div_step && dcnt_q != '0) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, cnt_q}) : CNT_W'(trial);
			quo_q <= {quo_q[PTR_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ROUL;
			pop_q       <= POP_W'(256);
			total_q     <= '0;
			step_q      <= '0;
			ptr_q       <= '0;
			srun_q      <= '0;
			spos_q      <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_MODE) mode_q <= cfg_data[MODE_W-1:0];
			if (cfg_we && cfg_index == REG_POP)  pop_q  <= cfg_data[POP_W-1:0];
			if (cmd.sum_step && at_end) total_q <= run_q;
			if (cmd.div_start) begin
				dcnt_q <= DCNT_W'(DIV_STEPS);
			end else if (cmd.div_step && dcnt_q != '0) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
			if (cmd.set_step) step_q <= quo_q;
			if (cmd.set_ptr) begin
				ptr_q  <= quo_q;
				srun_q <= '0;
				spos_q <= '0;
			end
			// sampling walk resumes where this one stopped
			if (cmd.walk_step && walk_done && samp) begin
				spos_q <= pos_q;
				srun_q <= run_q;
				ptr_q  <= ptr_sum[PTR_W] ? {PTR_W{1'b1}} : ptr_sum[PTR_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(spos_q) <= MAX_POPULATION)
		else $error("sampling position beyond table");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready))
		else $error("result overwritten before taken");
	a_ptr_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_step && walk_done && samp && !cmd.set_ptr) |=> ptr_q >= $past(ptr_q))
		else $error("sampling pointer moved backward");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(dcnt_q) <= DIV_STEPS)
		else $error("divider count out of range");

endmodule

FILE: tb/roulette_wheel_selector_checker.sv
// Checker for roulette_wheel_selector_top: watches request, result and config ports,
// predicts every selection and compares it with what the block returns.
// Depends on rws_pkg and the rws_in_if / rws_out_if interfaces.
`timescale 1ns / 100ps

module roulette_wheel_selector_checker import rws_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	rws_in_if                    in_ch,
	rws_out_if                   out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             past;
	} pick_t;

	logic [31:0]       cost_tbl [MAX_POP_DEF];
	logic [TOTAL_W-1:0] total;
	logic [PTR_W-1:0]  sus_step;
	logic [PTR_W-1:0]  sus_ptr;
	logic [63:0]       sus_run;
	int                sus_pos;
	logic [MODE_W-1:0] mode;
	logic [POP_W-1:0]  pop;
	pick_t             picks_due [$];

	assign pending = picks_due.size();

	function automatic int used_n();
		if (pop == 0) return 1;
		if (pop > MAX_POP_DEF) return MAX_POP_DEF;
		return int'(pop);
	endfunction

	// first entry whose running weight (scaled by 2^16) reaches the target
	function automatic int find_entry(input logic [63:0] target, inout int p,
			inout logic [63:0] s, input int n, input bit rank, output bit past);
		logic [63:0] cand;
		while (p < n) begin
			cand = s + (rank ? 64'(n - p) : 64'(cost_tbl[p]));
			if ((cand << 16) >= target) begin
				past = 1'b0;
				return p;
			end
			s = cand;
			p++;
		end
		past = 1'b1;
		return n - 1;
	endfunction

	task automatic predict();
		int          n;
		int          p;
		int          sel;
		logic [63:0] s;
		logic [63:0] cnt;
		logic [63:0] nxt;
		bit          past;
		n = used_n();
		case (op_t'(in_ch.opcode))
			OP_LOAD: cost_tbl[in_ch.entry_index] = in_ch.cost_value;
			OP_PREP: begin
				cnt = (in_ch.selection_count == 0) ? 64'd1 : 64'(in_ch.selection_count);
				if (mode == MODE_RANK) begin
					total = TOTAL_W'((64'(n) * 64'(n + 1)) / 2);
				end else begin
					s = 0;
					for (int i = 0; i < n; i++) s += cost_tbl[i];
					total = TOTAL_W'(s);
				end
				sus_step = PTR_W'((64'(total) << 16) / cnt);
				sus_ptr  = PTR_W'((64'(in_ch.random_fraction) * 64'(total)) / cnt);
				sus_run  = 0;
				sus_pos  = 0;
			end
			OP_SEL: begin
				if (mode == MODE_SUS) begin
					sel = find_entry(64'(sus_ptr), sus_pos, sus_run, n, 1'b0, past);
					nxt = 64'(sus_ptr) + 64'(sus_step);
					sus_ptr = (nxt > {PTR_W{1'b1}}) ? {PTR_W{1'b1}} : PTR_W'(nxt);
				end else begin
					p = 0;
					s = 0;
					sel = find_entry(64'(in_ch.random_fraction) * 64'(total), p, s, n,
						mode == MODE_RANK, past);
				end
				picks_due.push_back('{index: IDX_W'(sel), past: past});
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		pick_t want;
		if (!arst_n) begin
			errors   <= 0;
			total    = '0;
			sus_step = '0;
			sus_ptr  = '0;
			sus_run  = '0;
			sus_pos  = 0;
			mode     = '0;
			pop      = POP_W'(MAX_POP_DEF);
			picks_due.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MODE) mode = cfg_data[MODE_W-1:0];
				else if (cfg_index == REG_POP) pop = cfg_data[POP_W-1:0];
			end
			if (out_ch.valid && out_ch.ready) begin
				if (picks_due.size() == 0) begin
					$display("%0t: unexpected result index %0d past %0b", $time,
						out_ch.selected_index, out_ch.ran_past_end);
					errors <= errors + 1;
				end else begin
					want = picks_due.pop_front();
					if (want.index !== out_ch.selected_index
							|| want.past !== out_ch.ran_past_end) begin
						$display("%0t: mismatch expected index %0d past %0b, got index %0d past %0b",
							$time, want.index, want.past, out_ch.selected_index,
							out_ch.ran_past_end);
						errors <= errors + 1;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) predict();
		end
	end

endmodule

FILE: tb/roulette_wheel_selector_top_tb.sv
// Testbench top for roulette_wheel_selector_top: clock, reset, request and config
// stimulus, result-side stalls and the verdict. Checking is in roulette_wheel_selector_checker.
`timescale 1ns / 100ps

module roulette_wheel_selector_top_tb;
	import rws_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   idle_pct;
	int                   stall_pct;
	int                   sent;
	int                   cur_pop;

	rws_in_if  in_ch ();
	rws_out_if out_ch ();

	roulette_wheel_selector_top DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	roulette_wheel_selector_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

	task automatic issue(input op_t op, input int idx, input logic [31:0] cost,
			input int r, input int cnt);
		bit rdy;
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.opcode          <= op;
		in_ch.entry_index     <= IDX_W'(idx);
		in_ch.cost_value      <= cost;
		in_ch.random_fraction <= FRAC_W'(r);
		in_ch.selection_count <= CNT_W'(cnt);
		do begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
		end while (!rdy);
		sent++;
	endtask

	// hold requests until every selection is back and the block has drained
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_POP) cur_pop = val;
	endtask

	function automatic logic [31:0] pick_cost();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_round();
		int k;
		int c;
		int n;
		drain();
		if ($urandom_range(2) == 0) write_reg(REG_MODE, $urandom_range(0, 3));
		if ($urandom_range(2) == 0) begin
			case ($urandom_range(9))
				0: write_reg(REG_POP, 0);
				1: write_reg(REG_POP, 256);
				2, 3: write_reg(REG_POP, $urandom_range(0, 511));
				default: write_reg(REG_POP, $urandom_range(1, 24));
			endcase
		end
		n = (cur_pop == 0) ? 1 : (cur_pop > 256 ? 256 : cur_pop);
		repeat ($urandom_range(0, 3))
			issue(OP_LOAD, $urandom_range(0, n - 1), pick_cost(), $urandom, $urandom);
		c = ($urandom_range(4) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 12);
		issue(OP_PREP, $urandom, $urandom, $urandom, c);
		k = $urandom_range(1, (c > 12 || c == 0) ? 12 : c);
		if ($urandom_range(3) == 0) k += $urandom_range(1, 3);
		repeat (k) begin
			case ($urandom_range(15))
				0: issue(OP_NONE, $urandom, $urandom, $urandom, $urandom);
				1: issue(OP_LOAD, $urandom, pick_cost(), $urandom, $urandom);
				default: issue(OP_SEL, $urandom, $urandom, $urandom, $urandom);
			endcase
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.opcode    = OP_NONE;
		in_ch.entry_index     = '0;
		in_ch.cost_value      = '0;
		in_ch.random_fraction = '0;
		in_ch.selection_count = '0;
		idle_pct        = 0;
		stall_pct       = 0;
		sent            = 0;
		cur_pop         = 256;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table so no select or prepare ever reads a blank entry
		for (int i = 0; i < 256; i++)
			issue(OP_LOAD, i, (i == 0) ? 32'hFFFF_FFFF : pick_cost(), $urandom, $urandom);

		// directed corners
		issue(OP_PREP, 8'd0, 32'd0, 16'hFFFF, 9'd1);
		issue(OP_SEL, 8'd0, 32'd0, 16'h0000, 9'd0);
		issue(OP_SEL, 8'd0, 32'd0, 16'hFFFF, 9'd0);
		issue(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 9'h1FF);
		issue(OP_LOAD, 8'd255, 32'hFFFF_FFFF, 16'd0, 9'd0);
		issue(OP_SEL, 8'd0, 32'd0, 16'hFFFF, 9'd0);
		drain();
		write_reg(REG_MODE, MODE_RANK);
		issue(OP_PREP, 8'd0, 32'd0, 16'd0, 9'd256);
		issue(OP_SEL, 8'd0, 32'd0, 16'hFFFF, 9'd0);
		issue(OP_SEL, 8'd0, 32'd0, 16'd1, 9'd0);
		drain();
		write_reg(REG_MODE, MODE_SUS);
		write_reg(REG_POP, 5);
		issue(OP_PREP, 8'd0, 32'd0, 16'hFFFF, 9'd0);
		repeat (3) issue(OP_SEL, 8'd0, 32'd0, 16'd0, 9'd0);
		issue(OP_PREP, 8'd0, 32'd0, 16'h8000, 9'h1FF);
		repeat (3) issue(OP_SEL, 8'd0, 32'd0, 16'd0, 9'd0);
		drain();
		write_reg(REG_MODE, 3);
		write_reg(REG_POP, 0);
		issue(OP_PREP, 8'd0, 32'd0, 16'd0, 9'd1);
		issue(OP_SEL, 8'd0, 32'd0, 16'hFFFF, 9'd0);
		drain();
		write_reg(REG_POP, 511);
		issue(OP_SEL, 8'd0, 32'd0, 16'h1234, 9'd0);
		drain();
		write_reg(REG_MODE, MODE_ROUL);
		write_reg(REG_POP, 1);
		issue(OP_SEL, 8'd0, 32'd0, 16'hFFFF, 9'd0);

		sent = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 47; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 47; end
				3: begin idle_pct = 27; stall_pct = 27; end
				default: begin idle_pct = 0; stall_pct = 0; end
			endcase
			while (sent < (ph + 1) * 75) random_round();
		end

		drain();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/rws_pkg.sv
rtl/core/rws_if.sv
rtl/core/rws_ctrl.sv
rtl/core/rws_dp.sv
rtl/core/roulette_wheel_selector_top.sv
tb/roulette_wheel_selector_checker.sv
tb/roulette_wheel_selector_top_tb.sv
